>>> src/interval_overlap_finder_core_defines.svh
`ifndef INTERVAL_OVERLAP_FINDER_CORE_DEFINES_SVH
`define INTERVAL_OVERLAP_FINDER_CORE_DEFINES_SVH

// Concurrent check on a given clock and active-low reset.
`define IOF_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("interval_overlap_finder check failed");

// Same check on the core clock and reset.
`define IOF_ASSERT(lbl, prop) `IOF_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> src/iof_pkg.sv
`timescale 1ns / 1ps
package iof_pkg;

  localparam int unsigned MaxIntervalsDefault = 32;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CountWidth = 6;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    action_e                        action;
    logic signed [ValueWidth-1:0]   lo_value;
    logic signed [ValueWidth-1:0]   hi_value;
  } req_t;

  typedef struct packed {
    status_e                        status;
    logic [CountWidth-1:0]          overlap_count;
    logic signed [ValueWidth-1:0]   lo_bound;
    logic signed [ValueWidth-1:0]   hi_bound;
  } rsp_t;

endpackage

>>> src/iof_req_if.sv
`timescale 1ns / 1ps
interface iof_req_if;
  import iof_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/iof_rsp_if.sv
`timescale 1ns / 1ps
interface iof_rsp_if;
  import iof_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/iof_ram.sv
`timescale 1ns / 1ps
module iof_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/interval_overlap_finder_core.sv
// Channel  | Dir | Payload                               | Meaning
// ---------+-----+---------------------------------------+-------------------------
// req_i    | in  | action, lo_value, hi_value            | add / find / clear / nop request
// rsp_o    | out | status, overlap_count, lo/hi_bound    | one response per request
//
// Flow: clear, nop and rejected add go from idle straight to the response state.
// Add: every edge >= the new value moves up one slot, for the start edge, then the end edge.
// Find: scans forward from the head, then back from the tail; a failed pass
// repeats with a lower count until the count reaches zero.
// The edge RAM (one read, one write port, registered read) sets the pace.
// Reset: asynchronous, clears counts and handshake state; the RAM is not cleared.
// Stalls: a new request is taken while a finished response waits on rsp_o.
`timescale 1ns / 1ps
`include "interval_overlap_finder_core_defines.svh"
module interval_overlap_finder_core #(
  parameter int unsigned MaxIntervals = iof_pkg::MaxIntervalsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iof_req_if.sink    req_i,
  iof_rsp_if.source  rsp_o
);
  import iof_pkg::*;

  localparam int unsigned Depth = 2 * MaxIntervals;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned TW    = $clog2(Depth + 1);
  localparam int unsigned WW    = $clog2(MaxIntervals + 1);
  localparam int unsigned RW    = TW + 1;
  localparam int unsigned EW    = ValueWidth + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_FND_RD  = 3'd3;
  localparam logic [2:0] S_FND_CHK = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0]   state_q, state_d;
  logic [TW-1:0] total_q, total_d;
  logic [WW-1:0] wanted_q, wanted_d;
  logic [TW-1:0] idx_q, idx_d;
  logic signed [RW-1:0] run_q, run_d;
  logic back_q, back_d;       // find: scanning from the tail
  logic second_q, second_d;   // add: inserting the end edge
  logic signed [ValueWidth-1:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [ValueWidth-1:0] fwd_q, fwd_d;
  logic signed [ValueWidth-1:0] res_lo_q, res_lo_d, res_hi_q, res_hi_d;
  status_e status_q, status_d;
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_data_q, rsp_data_d;

  // edge RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  iof_ram #(.Width(EW), .Depth(Depth)) u_edges (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic signed [ValueWidth-1:0] rd_val, ins_val;
  logic rd_end;
  logic signed [RW-1:0] run_n, wanted_s;
  logic hit;
  logic [WW+CountWidth-1:0] cnt_ext;
  logic [TW:0] total_plus2;
  logic [TW-1:0] idx_dec;

  assign rd_val   = $signed(ram_rdata[ValueWidth-1:0]);
  assign rd_end   = ram_rdata[ValueWidth];
  assign ins_val  = second_q ? hi_q : lo_q;
  assign wanted_s = RW'(wanted_q);
  assign run_n    = (rd_end ^ back_q) ? run_q - RW'(1) : run_q + RW'(1);
  assign hit      = run_n >= wanted_s;
  assign cnt_ext  = (WW + CountWidth)'(wanted_q);
  assign total_plus2 = {1'b0, total_q} + (TW + 1)'(2);
  assign idx_dec  = idx_q - TW'(1);

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    wanted_d    = wanted_q;
    idx_d       = idx_q;
    run_d       = run_q;
    back_d      = back_q;
    second_d    = second_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    fwd_d       = fwd_q;
    res_lo_d    = res_lo_q;
    res_hi_d    = res_hi_q;
    status_d    = status_q;
    rsp_valid_d = rsp_valid_q;
    rsp_data_d  = rsp_data_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AW-1:0];
    ram_wdata   = {second_q, ins_val};
    ram_raddr   = idx_q[AW-1:0];

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          lo_d     = req_i.data.lo_value;
          hi_d     = req_i.data.hi_value;
          status_d = ST_OK;
          res_lo_d = '0;
          res_hi_d = '0;
          second_d = 1'b0;
          idx_d    = '0;
          run_d    = '0;
          back_d   = 1'b0;
          state_d  = S_RESP;
          case (req_i.data.action)
            ACT_ADD: begin
              if (req_i.data.hi_value < req_i.data.lo_value) begin
                status_d = ST_ORDER;
              end else if (total_plus2 > (TW + 1)'(Depth)) begin
                status_d = ST_FULL;
              end else begin
                idx_d   = total_q;
                state_d = S_INS_RD;
              end
            end
            ACT_FIND: begin
              if (wanted_q != '0) begin
                state_d = S_FND_RD;
              end
            end
            ACT_CLEAR: begin
              total_d  = '0;
              wanted_d = '0;
            end
            default: ;
          endcase
        end
      end

      // Walk down from the tail, moving each edge >= new value up one slot.
      S_INS_RD: begin
        if (idx_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          total_d   = total_q + TW'(1);
          if (!second_q) begin
            second_d = 1'b1;
            idx_d    = total_q + TW'(1);
          end else begin
            wanted_d = wanted_q + WW'(1);
            state_d  = S_RESP;
          end
        end else begin
          ram_raddr = idx_dec[AW-1:0];
          state_d   = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        ram_we = 1'b1;
        if (rd_val >= ins_val) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_dec;
          state_d   = S_INS_RD;
        end else begin
          total_d = total_q + TW'(1);
          if (!second_q) begin
            second_d = 1'b1;
            idx_d    = total_q + TW'(1);
            state_d  = S_INS_RD;
          end else begin
            wanted_d = wanted_q + WW'(1);
            state_d  = S_RESP;
          end
        end
      end

      S_FND_RD: begin
        if ((!back_q && idx_q == total_q) || (back_q && idx_q == '0)) begin
          // pass failed: lower the target and restart from the head
          wanted_d = wanted_q - WW'(1);
          idx_d    = '0;
          run_d    = '0;
          back_d   = 1'b0;
          if (wanted_q == WW'(1)) begin
            state_d = S_RESP;
          end
        end else begin
          ram_raddr = back_q ? idx_dec[AW-1:0] : idx_q[AW-1:0];
          state_d   = S_FND_CHK;
        end
      end

      S_FND_CHK: begin
        state_d = S_FND_RD;
        if (hit) begin
          if (!back_q) begin
            fwd_d  = rd_val;
            back_d = 1'b1;
            idx_d  = total_q;
            run_d  = '0;
          end else begin
            res_lo_d = fwd_q;
            res_hi_d = rd_val;
            state_d  = S_RESP;
          end
        end else begin
          run_d = run_n;
          idx_d = back_q ? idx_dec : idx_q + TW'(1);
        end
      end

      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d              = 1'b1;
          rsp_data_d.status        = status_q;
          rsp_data_d.overlap_count = cnt_ext[CountWidth-1:0];
          rsp_data_d.lo_bound      = res_lo_q;
          rsp_data_d.hi_bound      = res_hi_q;
          state_d                  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      wanted_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      wanted_q    <= wanted_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    run_q      <= run_d;
    back_q     <= back_d;
    second_q   <= second_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    fwd_q      <= fwd_d;
    res_lo_q   <= res_lo_d;
    res_hi_q   <= res_hi_d;
    status_q   <= status_d;
    rsp_data_q <= rsp_data_d;
  end

  `IOF_ASSERT(a_total_bound, {1'b0, total_q} <= (TW + 1)'(Depth))
  `IOF_ASSERT(a_wanted_half, ((TW + 1)'(wanted_q) << 1) <= {1'b0, total_q})
  `IOF_ASSERT(a_shift_idx, (state_q == S_INS_CMP) |-> (idx_q != '0))
  `IOF_ASSERT(a_resp_load, (state_q == S_RESP && !rsp_valid_q) |=> rsp_valid_q)

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import iof_pkg::*;

  localparam int unsigned EdgeDepth = 2 * MaxIntervalsDefault;
  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned RandItems = 1950;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  iof_req_if req_if ();
  iof_rsp_if rsp_if ();

  interval_overlap_finder_core u_top (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk = ~clk;

  // Own copy of the block state: sorted edge store and wanted count.
  logic signed [63:0] edge_val [EdgeDepth];
  bit                 edge_end [EdgeDepth];
  int unsigned        edge_cnt;
  int unsigned        wanted;

  rsp_t        rsp_pending[$];
  int unsigned errors;
  int unsigned n_added, n_order, n_full, n_finds, n_clears, n_hits;
  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  longint unsigned cycles;

  task automatic mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void put_edge(input logic signed [63:0] v, input bit is_end);
    int unsigned pos;
    pos = 0;
    while (pos < edge_cnt && edge_val[pos] < v) pos++;
    for (int unsigned k = edge_cnt; k > pos; k--) begin
      edge_val[k] = edge_val[k-1];
      edge_end[k] = edge_end[k-1];
    end
    edge_val[pos] = v;
    edge_end[pos] = is_end;
    edge_cnt++;
  endfunction

  // Marzullo scan: lower the agreement target until both ends are found.
  function automatic void best_overlap(output logic signed [63:0] lo_b,
                                       output logic signed [63:0] hi_b);
    int  run;
    bit  got_lo, got_hi;
    logic signed [63:0] lv, hv;
    lo_b = '0;
    hi_b = '0;
    while (wanted != 0) begin
      got_lo = 1'b0;
      got_hi = 1'b0;
      lv = '0;
      hv = '0;
      run = 0;
      for (int unsigned i = 0; i < edge_cnt; i++) begin
        run += edge_end[i] ? -1 : 1;
        if (run >= int'(wanted)) begin
          got_lo = 1'b1;
          lv = edge_val[i];
          break;
        end
      end
      run = 0;
      for (int unsigned i = edge_cnt; i > 0; i--) begin
        run += edge_end[i-1] ? 1 : -1;
        if (run >= int'(wanted)) begin
          got_hi = 1'b1;
          hv = edge_val[i-1];
          break;
        end
      end
      if (got_lo && got_hi) begin
        lo_b = lv;
        hi_b = hv;
        return;
      end
      wanted--;
    end
  endfunction

  function automatic rsp_t predict_response(input req_t r);
    rsp_t o;
    logic signed [63:0] lo, hi, lb, hb;
    lo = r.lo_value;
    hi = r.hi_value;
    o = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_ADD: begin
        if (hi < lo) begin
          o.status = ST_ORDER;
          n_order++;
        end else if (edge_cnt + 2 > EdgeDepth) begin
          o.status = ST_FULL;
          n_full++;
        end else begin
          put_edge(lo, 1'b0);
          put_edge(hi, 1'b1);
          wanted++;
          n_added++;
        end
      end
      ACT_FIND: begin
        best_overlap(lb, hb);
        o.lo_bound = lb;
        o.hi_bound = hb;
        n_finds++;
        if (wanted > 1) n_hits++;
      end
      ACT_CLEAR: begin
        edge_cnt = 0;
        wanted = 0;
        n_clears++;
      end
      default: ;
    endcase
    o.overlap_count = wanted[CountWidth-1:0];
    return o;
  endfunction

  // Offer one request; blocks until accepted. Valid stays high afterwards.
  task automatic send_request(input req_t r, input bit has_exp, input rsp_t exp_rsp);
    rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.data = r;
    do @(posedge clk); while (!req_if.ready);
    p = predict_response(r);
    rsp_pending.push_back(has_exp ? exp_rsp : p);
    @(negedge clk);
  endtask

  function automatic logic signed [63:0] rand_value();
    case ($urandom_range(7))
      0, 1, 2, 3: return longint'($urandom_range(200)) - 100;
      4:          return {$urandom, $urandom};
      5:          return longint'($urandom_range(3)) - 64'sh8000_0000_0000_0000 + 0;
      6:          return 64'sh7FFF_FFFF_FFFF_FFFF - longint'($urandom_range(3));
      default:    return longint'($urandom_range(6)) - 3;
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t r;
    int unsigned pick;
    logic signed [63:0] a, b;
    pick = $urandom_range(99);
    a = rand_value();
    b = rand_value();
    r.lo_value = a;
    r.hi_value = b;
    if (pick < 60) begin
      r.action = ACT_ADD;
      // mostly well-ordered intervals, some deliberately reversed
      if ($urandom_range(9) != 0) begin
        r.lo_value = (a < b) ? a : b;
        r.hi_value = (a < b) ? b : a;
      end
    end else if (pick < 95) begin
      r.action = ACT_FIND;
    end else if (pick < 98) begin
      r.action = ACT_CLEAR;
    end else begin
      r.action = ACT_NOP;
    end
    return r;
  endfunction

  typedef struct {
    action_e            action;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    bit                 has_exp;
    status_e            exp_status;
    int unsigned        exp_count;
    logic signed [63:0] exp_lo;
    logic signed [63:0] exp_hi;
  } dir_row_t;

  localparam logic signed [63:0] VMin = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] VMax = 64'sh7FFF_FFFF_FFFF_FFFF;

  dir_row_t dir_rows[] = '{
    '{ACT_FIND,  0,    0,    1, ST_OK,    0, 0,    0},     // empty store
    '{ACT_NOP,   -1,   -1,   1, ST_OK,    0, 0,    0},     // unused action
    '{ACT_ADD,   VMax, VMin, 1, ST_ORDER, 0, 0,    0},     // hi below lo
    '{ACT_ADD,   VMin, VMax, 1, ST_OK,    1, 0,    0},     // full range
    '{ACT_FIND,  0,    0,    1, ST_OK,    1, VMin, VMax},
    '{ACT_ADD,   5,    5,    1, ST_OK,    2, 0,    0},     // point interval
    '{ACT_ADD,   5,    10,   1, ST_OK,    3, 0,    0},
    '{ACT_ADD,   -3,   5,    1, ST_OK,    4, 0,    0},
    '{ACT_FIND,  0,    0,    0, ST_OK,    0, 0,    0},
    '{ACT_ADD,   20,   30,   0, ST_OK,    0, 0,    0},
    '{ACT_ADD,   6,    4,    0, ST_OK,    0, 0,    0},
    '{ACT_FIND,  0,    0,    0, ST_OK,    0, 0,    0},     // count drops
    '{ACT_ADD,   -2,   -1,   0, ST_OK,    0, 0,    0},
    '{ACT_FIND,  0,    0,    0, ST_OK,    0, 0,    0},
    '{ACT_CLEAR, VMax, VMax, 1, ST_OK,    0, 0,    0},
    '{ACT_FIND,  0,    0,    1, ST_OK,    0, 0,    0},
    '{ACT_ADD,   0,    0,    0, ST_OK,    0, 0,    0},
    '{ACT_ADD,   VMin, VMin, 0, ST_OK,    0, 0,    0},
    '{ACT_ADD,   VMax, VMax, 0, ST_OK,    0, 0,    0},
    '{ACT_FIND,  0,    0,    0, ST_OK,    0, 0,    0},
    '{ACT_CLEAR, 0,    0,    1, ST_OK,    0, 0,    0}
  };

  // Response side: random backpressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      rsp_if.ready = 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_pending.size() == 0) begin
        mismatch("response with nothing pending");
      end else begin
        e = rsp_pending.pop_front();
        if (rsp_if.data.status !== e.status)
          mismatch($sformatf("status got %0d exp %0d", rsp_if.data.status, e.status));
        if (rsp_if.data.overlap_count !== e.overlap_count)
          mismatch($sformatf("count got %0d exp %0d",
                             rsp_if.data.overlap_count, e.overlap_count));
        if (rsp_if.data.lo_bound !== e.lo_bound)
          mismatch($sformatf("lo_bound got %0d exp %0d",
                             rsp_if.data.lo_bound, e.lo_bound));
        if (rsp_if.data.hi_bound !== e.hi_bound)
          mismatch($sformatf("hi_bound got %0d exp %0d",
                             rsp_if.data.hi_bound, e.hi_bound));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    req_t  r;
    rsp_t  x;
    int unsigned phase_len;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    cycles = 0;
    errors = 0;
    edge_cnt = 0;
    wanted = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Directed table; typed expectations where obvious, predictor otherwise.
    foreach (dir_rows[i]) begin
      r.action = dir_rows[i].action;
      r.lo_value = dir_rows[i].lo;
      r.hi_value = dir_rows[i].hi;
      x.status = dir_rows[i].exp_status;
      x.overlap_count = dir_rows[i].exp_count[CountWidth-1:0];
      x.lo_bound = dir_rows[i].exp_lo;
      x.hi_bound = dir_rows[i].exp_hi;
      send_request(r, dir_rows[i].has_exp, x);
    end

    // Two idling regimes, then a long response hold-off with no idling.
    phase_len = RandItems / 3;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 73 : 0;
      recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 37 : 0;
      if (ph == 2) hold_req = 1'b1;
      for (int unsigned n = 0; n < phase_len; n++)
        send_request(rand_request(), 1'b0, x);
    end
    req_if.valid = 1'b0;

    while (rsp_pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d adds, %0d reversed, %0d full rejects, %0d clears",
             n_added, n_order, n_full, n_clears);
    $display("%0d finds (%0d with multi-interval agreement), %0d cycles",
             n_finds, n_hits, cycles);
    if (errors == 0 && rsp_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
